[hw/rtl/dcf_pkg.sv]
// Shared types, constants and helpers for the distance chain follower.
`default_nettype none
package dcf_pkg;
    localparam int NODES_DEF = 16;
    localparam int ITER_W = 52;

    localparam logic [15:0] LINK_LENGTH_RST = 16'd6400;
    localparam logic [8:0]  FOLLOW_GAIN_RST = 9'd26;

    localparam logic CFG_LINK_LENGTH = 1'b0;
    localparam logic CFG_FOLLOW_GAIN = 1'b1;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

    function automatic logic signed [23:0] sat24(input logic signed [ITER_W-1:0] v);
        logic signed [23:0] r;
        if (v > 52'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -52'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // reset spacing: 25 pixels apart, head at x = 1 pixel
    function automatic logic signed [23:0] node_reset_x(input logic [5:0] i);
        logic signed [23:0] r;
        r = 24'sd256 - $signed({18'b0, i}) * 24'sd6400;
        return r;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/dcf_iter.sv]
// Iterative square root and divide around one shared subtract/compare.
`default_nettype none
module dcf_iter
    import dcf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire iter_req_t         req,
    input  wire logic [ITER_W-1:0] opnd_n,
    input  wire logic [24:0]       opnd_d,
    output logic                   done,
    output logic [24:0]            result
);
    logic [ITER_W-1:0] acc_reg, acc_next;
    logic [ITER_W-1:0] sh_reg, sh_next;
    logic [ITER_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    iter_op_t          op_reg, op_next;
    logic [ITER_W:0]   diff;
    logic [ITER_W-1:0] sub_val;
    logic              ge;

    // the one subtractor both algorithms share
    assign sub_val = (op_reg == OP_SQRT) ? root_reg + sh_reg : sh_reg;
    assign diff    = {1'b0, acc_reg} - {1'b0, sub_val};
    assign ge      = !diff[ITER_W];

    always_comb begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done      = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = opnd_n;
            root_next = '0;
            if (req.op == OP_SQRT) begin
                sh_next  = ITER_W'(1) << 48;
                cnt_next = 5'd24;
            end else begin
                sh_next  = ITER_W'(opnd_d) << 16;
                cnt_next = 5'd16;
            end
        end else if (busy_reg) begin
            if (ge) begin
                acc_next = diff[ITER_W-1:0];
            end
            if (op_reg == OP_SQRT) begin
                root_next = ge ? (root_reg >> 1) + sh_reg : root_reg >> 1;
                sh_next   = sh_reg >> 2;
            end else begin
                root_next = {root_reg[ITER_W-2:0], ge};
                sh_next   = sh_reg >> 1;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        root_reg <= root_next;
    end

    // done is combinational with the last step, so take the updated value
    assign result = root_next[24:0];
endmodule
`default_nettype wire

[hw/rtl/distance_chain_follower.sv]
// Top level: chain follower sequencer, node store, multiplier and result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: target_x[15:0], target_y[31:16]
//  m_      | out | m_tvalid/m_tready  | m_tdata: node_index, node_x, node_y; tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each follower node runs a 25-step square root and two 17-step divides in dcf_iter,
// plus setup and write-back; a coincident node skips them. The next target beat is
// accepted only in idle, after every node of the chain has been written back.
// s_tready is high only while idle.
// Reset (synchronous, aresetn low) restores the start-up chain through per-node
// valid bits, so no clearing pass is needed.
// A stalled m_ side holds the sequencer at each node write-back; the last node
// may still wait in the output register while the next target is accepted.
`default_nettype none
module distance_chain_follower
    import dcf_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // target_x[15:0], target_y[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // node_index[5:0], node_x[29:6], node_y[53:30], 0
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_HX    = 17'h00002,
        S_HY    = 17'h00004,
        S_HF    = 17'h00008,
        S_WB    = 17'h00010,
        S_FD    = 17'h00020,
        S_FDIFF = 17'h00040,
        S_SQX   = 17'h00080,
        S_SQY   = 17'h00100,
        S_SUM   = 17'h00200,
        S_SQRT  = 17'h00400,
        S_MULX  = 17'h00800,
        S_DIVX  = 17'h01000,
        S_WDX   = 17'h02000,
        S_MULY  = 17'h04000,
        S_DIVY  = 17'h08000,
        S_WDY   = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [15:0] link_len_reg;
    logic [8:0]  gain_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_len_reg <= LINK_LENGTH_RST;
            gain_reg     <= FOLLOW_GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LINK_LENGTH: link_len_reg <= cfg_data;
                CFG_FOLLOW_GAIN: gain_reg     <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // node store: registered read at idx_reg, valid bits stand in for reset
    logic signed [23:0] pos_x_mem [NODES];
    logic signed [23:0] pos_y_mem [NODES];
    logic [NODES-1:0]   valid_reg;
    logic signed [23:0] rd_x_reg, rd_y_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic signed [23:0] cur_x, cur_y;
    logic               wr_en;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [23:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [23:0] prev_x_reg, prev_y_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_x_mem[idx_reg] <= nx_reg;
            pos_y_mem[idx_reg] <= ny_reg;
        end
        rd_x_reg   <= pos_x_mem[idx_reg];
        rd_y_reg   <= pos_y_mem[idx_reg];
        rd_idx_reg <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[idx_reg];
        end
    end

    assign cur_x = rd_valid_reg ? rd_x_reg : node_reset_x(6'(rd_idx_reg));
    assign cur_y = rd_valid_reg ? rd_y_reg : 24'sd256;

    // target latch
    logic signed [15:0] tx_reg, ty_reg;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tx_reg <= s_tdata[15:0];
            ty_reg <= s_tdata[31:16];
        end
    end

    // shared multiplier, registered product
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] prod_reg;
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    logic signed [24:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [24:0]        ax, ay;
    logic [49:0]        sum_reg;
    logic [24:0]        mag_reg;
    logic signed [24:0] gx, gy;
    logic signed [51:0] step_v;

    assign ax = dx_reg[24] ? 25'(-dx_reg) : dx_reg;
    assign ay = dy_reg[24] ? 25'(-dy_reg) : dy_reg;
    assign gx = $signed({tx_reg[15], tx_reg, 8'b0}) - 25'(cur_x);
    assign gy = $signed({ty_reg[15], ty_reg, 8'b0}) - 25'(cur_y);
    // head step: floor((g*gain + 128) / 256)
    assign step_v = (prod_reg + 52'sd128) >>> 8;

    // iterative unit
    iter_req_t         req;
    logic [ITER_W-1:0] it_n;
    logic              it_done;
    logic [24:0]       it_res;

    dcf_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opnd_n  (it_n),
        .opnd_d  (mag_reg),
        .done    (it_done),
        .result  (it_res)
    );

    // follower result: prev - sign(d) * q
    logic signed [ITER_W-1:0] q_s;
    logic signed [23:0]       fx, fy;
    assign q_s = $signed({27'b0, it_res});
    assign fx  = sat24(ITER_W'(prev_x_reg) - (dx_reg[24] ? -q_s : q_s));
    assign fy  = sat24(ITER_W'(prev_y_reg) - (dy_reg[24] ? -q_s : q_s));

    logic out_free;
    assign out_free = !m_tvalid || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        mul_a      = '0;
        mul_b      = '0;
        req        = '{start: 1'b0, op: OP_SQRT};
        it_n       = '0;
        wr_en      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_HX;
                end
            end
            S_HX: begin
                mul_a      = 26'(gx);
                mul_b      = $signed({17'b0, gain_reg});
                state_next = S_HY;
            end
            S_HY: begin
                nx_next    = sat24(ITER_W'(cur_x) + step_v);
                mul_a      = 26'(gy);
                mul_b      = $signed({17'b0, gain_reg});
                state_next = S_HF;
            end
            S_HF: begin
                ny_next    = sat24(ITER_W'(cur_y) + step_v);
                state_next = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    wr_en = 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FD;
                    end
                end
            end
            S_FD: begin
                state_next = S_FDIFF;
            end
            S_FDIFF: begin
                dx_next = 25'(prev_x_reg) - 25'(cur_x);
                dy_next = 25'(prev_y_reg) - 25'(cur_y);
                if (prev_x_reg == cur_x && prev_y_reg == cur_y) begin
                    // coincident node stays put
                    nx_next    = cur_x;
                    ny_next    = cur_y;
                    state_next = S_WB;
                end else begin
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                mul_a      = $signed({1'b0, ax});
                mul_b      = $signed({1'b0, ax});
                state_next = S_SQY;
            end
            S_SQY: begin
                mul_a      = $signed({1'b0, ay});
                mul_b      = $signed({1'b0, ay});
                state_next = S_SUM;
            end
            S_SUM: begin
                req        = '{start: 1'b1, op: OP_SQRT};
                it_n       = ITER_W'(sum_reg + prod_reg[49:0]);
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if (it_done) begin
                    state_next = S_MULX;
                end
            end
            S_MULX: begin
                mul_a      = $signed({1'b0, ax});
                mul_b      = $signed({10'b0, link_len_reg});
                state_next = S_DIVX;
            end
            S_DIVX: begin
                req        = '{start: 1'b1, op: OP_DIV};
                it_n       = prod_reg + ITER_W'(mag_reg >> 1);
                state_next = S_WDX;
            end
            S_WDX: begin
                if (it_done) begin
                    nx_next    = fx;
                    state_next = S_MULY;
                end
            end
            S_MULY: begin
                mul_a      = $signed({1'b0, ay});
                mul_b      = $signed({10'b0, link_len_reg});
                state_next = S_DIVY;
            end
            S_DIVY: begin
                req        = '{start: 1'b1, op: OP_DIV};
                it_n       = prod_reg + ITER_W'(mag_reg >> 1);
                state_next = S_WDY;
            end
            S_WDY: begin
                if (it_done) begin
                    ny_next    = fy;
                    state_next = S_WB;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        if (state_reg == S_SQY) begin
            sum_reg <= prod_reg[49:0];
        end
        if (state_reg == S_SQRT && it_done) begin
            mag_reg <= it_res;
        end
        if (wr_en) begin
            prev_x_reg <= nx_reg;
            prev_y_reg <= ny_reg;
        end
    end

    // result register: loads a beat at each node write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (wr_en) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
        if (wr_en) begin
            m_tdata <= {2'b0, ny_reg, nx_reg, 6'(idx_reg)};
            m_tlast <= (idx_reg == LAST_IDX);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/dcf_checker.sv]
// Port-level checker for the distance chain follower, bound to the top level.
`default_nettype none
module dcf_checker
    import dcf_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tlast
);
    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // a target keeps the follower busy; no second accept right after
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // last flag marks the final node index only
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == 6'(NODES - 1))))
        else $error("tlast does not match node index");

    // reset empties the result register
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind distance_chain_follower dcf_checker #(.NODES(NODES)) u_dcf_checker (.*);
`default_nettype wire
